// File: src/voltage_soc_compensation_unit_macros.svh
// Assertion macros shared by the voltage SOC compensation RTL.
`ifndef VOLTAGE_SOC_COMPENSATION_UNIT_MACROS_SVH
`define VOLTAGE_SOC_COMPENSATION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define VSC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define VSC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define VSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VSC_ASSERT_ALWAYS(label, cond, msg)
`define VSC_ASSERT_IMPLY(label, ante, cons, msg)
`define VSC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: src/vsc_pkg.sv
// Types, constants and segment table for the voltage SOC compensation unit.
`timescale 1ns / 1ps
package vsc_pkg;

  // Configuration register indexes.
  localparam logic [7:0] CFG_FULL_CAPACITY    = 8'd0;
  localparam logic [7:0] CFG_NOMINAL_CAPACITY = 8'd1;

  localparam logic [15:0] FULL_CAPACITY_RESET    = 16'd8000;
  localparam logic [15:0] NOMINAL_CAPACITY_RESET = 16'd10666;

  // Gauge register addresses, in the order they are written.
  localparam logic [7:0] ADDR_REM_CAP      = 8'h05;
  localparam logic [7:0] ADDR_SOC_REP      = 8'h06;
  localparam logic [7:0] ADDR_SOC_MIX      = 8'h0D;
  localparam logic [7:0] ADDR_REM_CAP_MIX  = 8'h0F;
  localparam logic [7:0] ADDR_FULL_CAP     = 8'h10;
  localparam logic [7:0] ADDR_DESIGN_CAP   = 8'h23;
  localparam logic [7:0] ADDR_DQ_ACC       = 8'h45;
  localparam logic [7:0] ADDR_DP_ACC       = 8'h46;

  localparam logic [15:0] DP_ACC_VALUE = 16'h3200;

  // Voltage curve constants.
  localparam int unsigned  SEG_COUNT    = 10;
  localparam logic [3:0]   SEG_LAST     = 4'd9;
  localparam logic [12:0]  SEG_FLOOR_MV = 13'd3400;
  localparam logic [22:0]  SOC_SCALE    = 23'd2000;
  localparam logic [8:0]   MV_PER_NIBBLE = 9'd320;
  localparam logic [7:0]   FRAC_MIN     = 8'd52;
  localparam logic [7:0]   SOC_MAX      = 8'd140;
  // floor(2^24 / 25) for the divide by one hundred.
  localparam logic [19:0]  RECIP_25     = 20'd671088;
  localparam logic [21:0]  DIV_25       = 22'd25;

  typedef struct packed {
    logic [12:0] from_mv;
    logic [12:0] offset_mv;
    logic [15:0] divisor;
    logic [11:0] recip;     // floor(2^24 / (2 * divisor))
  } seg_t;

  typedef struct packed {
    logic [7:0]  soc;
    logic [7:0]  diff;
    logic [15:0] rem_cap;
  } entry_t;

  function automatic seg_t seg_of(input logic [3:0] idx);
    seg_t s;
    case (idx)
      4'd0:    s = '{13'd4125, 13'd1682, 16'd24495, 12'd342};
      4'd1:    s = '{13'd4049, 13'd3162, 16'd9653,  12'd869};
      4'd2:    s = '{13'd3931, 13'd3342, 16'd7692,  12'd1090};
      4'd3:    s = '{13'd3784, 13'd3454, 16'd6231,  12'd1346};
      4'd4:    s = '{13'd3731, 13'd3627, 16'd2957,  12'd2836};
      4'd5:    s = '{13'd3681, 13'd3625, 16'd3025,  12'd2773};
      4'd6:    s = '{13'd3637, 13'd3542, 16'd7498,  12'd1118};
      4'd7:    s = '{13'd3610, 13'd3592, 16'd3514,  12'd2387};
      4'd8:    s = '{13'd3549, 13'd3473, 16'd27435, 12'd305};
      default: s = '{13'd3400, 13'd3399, 16'd53905, 12'd155};
    endcase
    return s;
  endfunction

endpackage

// File: src/vsc_front.sv
// Front pipeline: converts voltage, decodes SOC, divides per segment, scales capacity.
`timescale 1ns / 1ps
`include "voltage_soc_compensation_unit_macros.svh"
module vsc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          cell_voltage_raw,
  input  logic [15:0]          reported_soc_raw,
  input  logic                 charger_present,
  input  logic [15:0]          full_capacity,
  input  logic                 queue_full,
  output logic                 push,
  output vsc_pkg::entry_t      push_data
);

  logic        v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic        advance;

  logic [12:0] mv1, mv2;
  logic [7:0]  rep1, rep2, rep3, rep4, rep5;
  logic [3:0]  seg2;
  logic        low2;
  logic [22:0] n3, n4, n5;
  logic [16:0] den3, den4, den5;
  logic [11:0] rcp3;
  logic [7:0]  q4, q5;
  logic [22:0] qd5;
  logic [7:0]  soc6, soc7, soc8;
  logic [7:0]  diff6, diff7, diff8;
  logic [23:0] fcs7;
  logic [21:0] y8;
  logic [16:0] q2_8;
  vsc_pkg::entry_t entry9;

  // Stage 1 logic: millivolts in two scaled parts, reported percent.
  logic [14:0] lo_x5;
  logic [12:0] hi_mv;
  logic [12:0] mv_c;
  logic [7:0]  rep_c;
  always_comb begin
    lo_x5 = 15'(cell_voltage_raw[11:0]) * 15'd5;
    hi_mv = 13'(cell_voltage_raw[15:12]) * 13'(vsc_pkg::MV_PER_NIBBLE);
    mv_c  = 13'(lo_x5[14:6]) + hi_mv;
    rep_c = reported_soc_raw[15:8];
    if (rep_c == 8'd0 && reported_soc_raw[7:0] >= vsc_pkg::FRAC_MIN) begin
      rep_c = 8'd1;
    end
  end

  // Stage 2 logic: first segment whose start lies at or below the voltage.
  logic [3:0] seg_c;
  always_comb begin
    seg_c = vsc_pkg::SEG_LAST;
    for (int i = vsc_pkg::SEG_COUNT - 1; i >= 0; i--) begin
      if (mv1 >= vsc_pkg::seg_of(4'(i)).from_mv) begin
        seg_c = 4'(i);
      end
    end
  end

  // Stage 3 logic: soc = floor((2000*d + div) / (2*div)), the rounded percent.
  vsc_pkg::seg_t seg3_c;
  logic [12:0]   d3_c;
  always_comb begin
    seg3_c = vsc_pkg::seg_of(seg2);
    d3_c   = mv2 - seg3_c.offset_mv;
  end

  // Stage 4 logic: quotient estimate, low by at most one.
  logic [34:0] p4_c;
  assign p4_c = 35'(n3) * 35'(rcp3);

  // Stage 5 logic: back-multiply the estimate.
  logic [24:0] qd5_c;
  assign qd5_c = 25'(q4) * 25'(den4);

  // Stage 6 logic: correct the estimate and compare with the reported percent.
  logic [22:0] r6_c;
  logic [7:0]  soc6_c;
  always_comb begin
    r6_c   = n5 - qd5;
    soc6_c = q5 + 8'(r6_c >= 23'(den5));
  end

  // Stage 8 logic: divide by one hundred as a quarter, then by 25 by reciprocal.
  logic [21:0] y8_c;
  logic [41:0] p8_c;
  assign y8_c = fcs7[23:2];
  assign p8_c = 42'(y8_c) * 42'(vsc_pkg::RECIP_25);

  // Stage 9 logic: one correction step on the quotient.
  logic [21:0] r9_c;
  logic [16:0] rem9_c;
  always_comb begin
    r9_c   = y8 - 22'(q2_8) * vsc_pkg::DIV_25;
    rem9_c = q2_8 + 17'(r9_c >= vsc_pkg::DIV_25);
  end

  assign advance  = !v9 || !queue_full;
  assign in_ready = advance;
  assign push     = v9 && advance;
  assign push_data = entry9;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9} <= '0;
    end else if (advance) begin
      // Words with the charger present cause no writes and are dropped here.
      v1 <= in_valid && !charger_present;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mv1  <= mv_c;
      rep1 <= rep_c;

      mv2  <= mv1;
      rep2 <= rep1;
      seg2 <= seg_c;
      low2 <= mv1 < vsc_pkg::SEG_FLOOR_MV;

      n3   <= low2 ? 23'd0 : 23'(d3_c) * vsc_pkg::SOC_SCALE + 23'(seg3_c.divisor);
      den3 <= {seg3_c.divisor, 1'b0};
      rcp3 <= seg3_c.recip;
      rep3 <= rep2;

      q4   <= p4_c[31:24];
      n4   <= n3;
      den4 <= den3;
      rep4 <= rep3;

      qd5  <= qd5_c[22:0];
      q5   <= q4;
      n5   <= n4;
      den5 <= den4;
      rep5 <= rep4;

      soc6  <= soc6_c;
      diff6 <= (soc6_c >= rep5) ? soc6_c - rep5 : rep5 - soc6_c;

      fcs7  <= 24'(full_capacity) * 24'(soc6);
      soc7  <= soc6;
      diff7 <= diff6;

      y8    <= y8_c;
      q2_8  <= p8_c[40:24];
      soc8  <= soc7;
      diff8 <= diff7;

      entry9.soc     <= soc8;
      entry9.diff    <= diff8;
      entry9.rem_cap <= rem9_c[15:0];
    end
  end

  `VSC_ASSERT_IMPLY(a_soc_estimate_close, v5, (n5 - qd5) < 23'({den5, 1'b0}), "soc estimate off by more than one")
  `VSC_ASSERT_IMPLY(a_soc_in_range, v7, soc7 <= vsc_pkg::SOC_MAX, "voltage soc above curve maximum")

endmodule

// File: src/vsc_queue.sv
// Small FIFO between the front pipeline and the write sequencer.
`timescale 1ns / 1ps
`include "voltage_soc_compensation_unit_macros.svh"
module vsc_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vsc_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output vsc_pkg::entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vsc_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `VSC_ASSERT_ALWAYS(a_no_overflow, !(push && full && !pop), "queue written while full")
  `VSC_ASSERT_ALWAYS(a_no_underflow, !(pop && !not_empty), "queue read while empty")

endmodule

// File: src/vsc_back.sv
// Write sequencer: turns one queued result into eight gauge register words.
`timescale 1ns / 1ps
`include "voltage_soc_compensation_unit_macros.svh"
module vsc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  vsc_pkg::entry_t q_data,
  output logic            q_pop,
  input  logic [15:0]     full_capacity,
  input  logic [15:0]     nominal_capacity,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [39:0]     m_tdata,
  output logic            m_tlast
);

  typedef enum logic [2:0] {
    STEP_REM,
    STEP_SOC,
    STEP_SOC_MIX,
    STEP_REM_MIX,
    STEP_FULL,
    STEP_NOM,
    STEP_NOM_QTR,
    STEP_DP_ACC
  } step_t;

  step_t       step;
  logic        load;
  logic [7:0]  addr_c;
  logic [15:0] value_c;
  logic [7:0]  out_addr;
  logic [15:0] out_value;
  logic [7:0]  out_soc;
  logic [7:0]  out_diff;

  always_comb begin
    case (step)
      STEP_REM: begin
        addr_c  = vsc_pkg::ADDR_REM_CAP;
        value_c = q_data.rem_cap;
      end
      STEP_SOC: begin
        addr_c  = vsc_pkg::ADDR_SOC_REP;
        value_c = {q_data.soc, 8'h00};
      end
      STEP_SOC_MIX: begin
        addr_c  = vsc_pkg::ADDR_SOC_MIX;
        value_c = {q_data.soc, 8'h00};
      end
      STEP_REM_MIX: begin
        addr_c  = vsc_pkg::ADDR_REM_CAP_MIX;
        value_c = q_data.rem_cap;
      end
      STEP_FULL: begin
        addr_c  = vsc_pkg::ADDR_FULL_CAP;
        value_c = full_capacity;
      end
      STEP_NOM: begin
        addr_c  = vsc_pkg::ADDR_DESIGN_CAP;
        value_c = nominal_capacity;
      end
      STEP_NOM_QTR: begin
        addr_c  = vsc_pkg::ADDR_DQ_ACC;
        value_c = {2'b00, nominal_capacity[15:2]};
      end
      STEP_DP_ACC: begin
        addr_c  = vsc_pkg::ADDR_DP_ACC;
        value_c = vsc_pkg::DP_ACC_VALUE;
      end
      default: begin
        addr_c  = vsc_pkg::ADDR_DP_ACC;
        value_c = vsc_pkg::DP_ACC_VALUE;
      end
    endcase
  end

  // A new word loads when a queued result waits and the output register is empty or being taken.
  assign load  = q_valid && (!m_tvalid || m_tready);
  assign q_pop = load && (step == STEP_DP_ACC);

  assign m_tdata = {out_diff, out_soc, out_value, out_addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= STEP_REM;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      if (load) begin
        step      <= step_t'(step + 3'd1);
        m_tvalid  <= 1'b1;
        m_tlast   <= step == STEP_DP_ACC;
        out_addr  <= addr_c;
        out_value <= value_c;
        out_soc   <= q_data.soc;
        out_diff  <= q_data.diff;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `VSC_ASSERT_IMPLY(a_last_on_final_addr, m_tvalid, m_tlast == (out_addr == vsc_pkg::ADDR_DP_ACC), "tlast does not match final register")
  `VSC_ASSERT_NEXT(a_run_restarts, q_pop, step == STEP_REM, "sequence did not restart after last word")

endmodule

// File: src/voltage_soc_compensation_unit.sv
// Top level of the voltage SOC compensation unit.
//
// Input stream (s_*): one word per sample, tdata carries the raw cell voltage
// and the raw reported SOC, tuser carries the charger-present flag. A sample
// with the charger present is taken from the stream and causes no output.
// Every other sample causes eight gauge register writes on the output stream
// (m_*), one word each, with tlast on the eighth.
// Configuration: cfg_valid/cfg_index/cfg_data write full capacity (index 0)
// or nominal capacity (index 1); cfg_ready is always high. Write only while idle.
// A sample's first write word passes through a nine-stage arithmetic pipeline,
// the queue and the output register. The sequencer emits one register word
// per cycle while the receiver takes them, so each sample occupies it for
// eight words, and it takes the next sample once its last word is loaded.
// The pipeline keeps accepting while the queue has room, so a new sample can
// enter while words still go out. When the receiver stalls, the output word
// holds, the queue fills and then s_tready falls. Reset clears the pipeline,
// queue and sequencer and restores full capacity 8000 and nominal capacity 10666.
`timescale 1ns / 1ps
module voltage_soc_compensation_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // cell_voltage_raw [15:0], reported_soc_raw [31:16]
  input  logic        s_tuser,   // charger_present [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // reg_address [7:0], reg_value [23:8],
                                 // voltage_soc [31:24], soc_difference [39:32]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]     full_capacity;
  logic [15:0]     nominal_capacity;
  logic            push;
  logic            queue_full;
  logic            queue_valid;
  logic            pop;
  vsc_pkg::entry_t push_data;
  vsc_pkg::entry_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_capacity    <= vsc_pkg::FULL_CAPACITY_RESET;
      nominal_capacity <= vsc_pkg::NOMINAL_CAPACITY_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == vsc_pkg::CFG_FULL_CAPACITY) begin
        full_capacity <= cfg_data;
      end else if (cfg_index == vsc_pkg::CFG_NOMINAL_CAPACITY) begin
        nominal_capacity <= cfg_data;
      end
    end
  end

  vsc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .cell_voltage_raw (s_tdata[15:0]),
    .reported_soc_raw (s_tdata[31:16]),
    .charger_present  (s_tuser),
    .full_capacity    (full_capacity),
    .queue_full       (queue_full),
    .push             (push),
    .push_data        (push_data)
  );

  vsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_valid),
    .head      (head)
  );

  vsc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (queue_valid),
    .q_data           (head),
    .q_pop            (pop),
    .full_capacity    (full_capacity),
    .nominal_capacity (nominal_capacity),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast)
  );

endmodule
